### design/assert_macros.svh
// Concurrent assertion helpers; each use needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SET    = 2'd1,
        OP_GET    = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GET_WAIT,
        ST_DEL_CHECK,
        ST_DEL_MOVE,
        ST_DEL_FIN
    } state_t;

    typedef struct packed {
        logic req_load;
        logic wr_req;
        logic wr_shift;
        logic rd_get;
        logic rd_shift;
        logic ptr_init;
        logic ptr_inc;
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  req_op;
        logic in_range;
        logic not_full;
        logic shift_more;
        logic slot_free;
    } status_t;

endpackage

### design/ils_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ils_ctrl
    import ils_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.req_op)
                    OP_APPEND, OP_SET:
                    begin
                        if (status.slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_GET:
                    begin
                        if (status.in_range)
                        begin
                            state_next = ST_GET_WAIT;
                        end
                        else if (status.slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (status.in_range)
                        begin
                            state_next = ST_DEL_CHECK;
                        end
                        else if (status.slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_GET_WAIT:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEL_CHECK:
            begin
                state_next = status.shift_more ? ST_DEL_MOVE : ST_DEL_FIN;
            end
            ST_DEL_MOVE:
            begin
                state_next = ST_DEL_CHECK;
            end
            ST_DEL_FIN:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.req_load = in_valid;
            end
            ST_EXEC:
            begin
                unique case (status.req_op)
                    OP_APPEND:
                    begin
                        if (status.slot_free)
                        begin
                            cmd.wr_req   = status.not_full;
                            cmd.cnt_inc  = status.not_full;
                            cmd.out_load = 1'b1;
                        end
                    end
                    OP_SET:
                    begin
                        if (status.slot_free)
                        begin
                            cmd.wr_req   = status.in_range;
                            cmd.out_load = 1'b1;
                        end
                    end
                    OP_GET:
                    begin
                        cmd.rd_get   = status.in_range;
                        cmd.out_load = !status.in_range && status.slot_free;
                    end
                    OP_DELETE:
                    begin
                        cmd.ptr_init = status.in_range;
                        cmd.out_load = !status.in_range && status.slot_free;
                    end
                endcase
            end
            ST_GET_WAIT:
            begin
                cmd.out_load = status.slot_free;
            end
            ST_DEL_CHECK:
            begin
                cmd.rd_shift = status.shift_more;
            end
            ST_DEL_MOVE:
            begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = 1'b1;
            end
            ST_DEL_FIN:
            begin
                cmd.cnt_dec  = status.slot_free;
                cmd.out_load = status.slot_free;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_move_after_read, state_reg == ST_DEL_MOVE,
                    $past(state_reg) == ST_DEL_CHECK, "shift write without a preceding read")
    `ASSERT_IMPLIES(a_wait_after_get, state_reg == ST_GET_WAIT,
                    status.req_op == OP_GET && status.in_range, "read wait without an in-range get")
    `ASSERT_IMPLIES(a_load_on_transfer, cmd.req_load,
                    in_valid && in_ready, "request load without an input transfer")

endmodule

### design/ils_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ils_datapath
    import ils_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [1:0]                 opcode,
    input  logic [INDEX_W-1:0]         index,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   read_value,
    output logic [LENGTH_W-1:0]        length,
    output logic                       done_res
);

    logic [DATA_W-1:0]  mem [CAPACITY];

    op_t                 req_op_reg;
    logic [INDEX_W-1:0]  req_idx_reg;
    logic [DATA_W-1:0]   req_val_reg;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [ADDR_W-1:0]   ptr_reg;
    logic [DATA_W-1:0]   rd_data_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    logic                out_done_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                in_range;
    logic                not_full;
    logic                shift_more;
    logic                slot_free;

    assign in_range   = 32'(req_idx_reg) < 32'(count_reg);
    assign not_full   = 32'(count_reg) < CAPACITY;
    assign shift_more = (32'(ptr_reg) + 32'd1) < 32'(count_reg);
    assign slot_free  = !out_valid_reg || out_ready;

    assign status.req_op     = req_op_reg;
    assign status.in_range   = in_range;
    assign status.not_full   = not_full;
    assign status.shift_more = shift_more;
    assign status.slot_free  = slot_free;

    assign wr_en   = cmd.wr_req || cmd.wr_shift;
    assign rd_en   = cmd.rd_get || cmd.rd_shift;
    assign rd_addr = cmd.rd_shift ? ADDR_W'(32'(ptr_reg) + 32'd1) : ADDR_W'(req_idx_reg);

    always_comb
    begin
        priority if (cmd.wr_shift)
        begin
            wr_addr = ptr_reg;
            wr_data = rd_data_reg;
        end
        else if (req_op_reg == OP_APPEND)
        begin
            wr_addr = ADDR_W'(count_reg);
            wr_data = req_val_reg;
        end
        else
        begin
            wr_addr = ADDR_W'(req_idx_reg);
            wr_data = req_val_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_op_reg  <= op_t'(opcode);
            req_idx_reg <= index;
            req_val_reg <= value;
        end
        if (cmd.ptr_init)
        begin
            ptr_reg <= ADDR_W'(req_idx_reg);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + ADDR_W'(1);
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= (req_op_reg == OP_GET && in_range) ? rd_data_reg : '0;
            out_length_reg <= LENGTH_W'(count_next);
            out_done_reg   <= (req_op_reg == OP_APPEND) ? not_full : in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            priority if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign length     = out_length_reg;
    assign done_res   = out_done_reg;

    `ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= CAPACITY, "entry count above capacity")
    `ASSERT_IMPLIES(a_load_into_free_slot, cmd.out_load, slot_free, "result overwrites an untaken result")
    `ASSERT_IMPLIES(a_shift_in_range, cmd.wr_shift, 32'(ptr_reg) + 32'd1 < 32'(count_reg), "shift beyond the list end")

endmodule

### design/indexed_list_store_unit.sv
`timescale 1ns / 1ps
// Indexed list store: a bounded list of signed 32-bit words with a length count.
// Input channel (in_valid/in_ready) carries opcode, index and value; each request
// gives exactly one result on the output channel (out_valid/out_ready) holding
// read_value, length and done_res.
// A request is taken into a request register in the idle state, so one request
// can wait there while the previous result sits untaken in the output register.
// Steps from input transfer to result, with the output free:
//   append, set, out-of-range get or delete: result loaded from the execute state.
//   in-range get: one registered memory read, then the result is loaded.
//   in-range delete: each later entry, from index + 1 to length - 1, takes a
//   registered read followed by a write one place lower; then the result loads.
// After the result is loaded the block returns to idle and takes the next request.
// When the receiver stalls, the result holds and the block finishes at most one
// further request up to its own result, then waits.
// Reset clears the length count and the output valid; memory contents are
// undefined until written, and no clearing pass runs.
module indexed_list_store_unit
    import ils_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [INDEX_W-1:0]         index,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   read_value,
    output logic [LENGTH_W-1:0]        length,
    output logic                       done_res
);

    cmd_t    cmd;
    status_t status;

    ils_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ils_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .opcode     (opcode),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .length     (length),
        .done_res   (done_res)
    );

endmodule

### tb/indexed_list_store_unit_test.sv
`timescale 1ns / 1ps

module indexed_list_store_unit_test;
    import ils_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [LENGTH_W-1:0]      len;
        logic                     done;
    } list_result_t;

    typedef struct packed {
        op_t                      op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
        logic                     pinned;
        list_result_t             res;
    } stim_row_t;

    typedef enum logic [1:0] {
        SINK_STEADY,
        SINK_HOLD,
        SINK_CHOPPY
    } sink_mode_t;

    localparam int DIRECTED_ROWS   = 23;
    localparam int SHORT_LIST_OPS  = 250;
    localparam int FULL_LIST_OPS   = 300;
    localparam int SETTLE_CYCLES   = 20;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               opcode = '0;
    logic [INDEX_W-1:0]       index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic [LENGTH_W-1:0]      length;
    logic                     done_res;

    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       list_len = 0;
    list_result_t             pending_results [$];
    int                       error_count = 0;
    int                       burst_left = 0;
    sink_mode_t               sink_mode = SINK_HOLD;
    int                       sink_left = 0;
    stim_row_t                directed_rows [DIRECTED_ROWS];

    indexed_list_store_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .length     (length),
        .done_res   (done_res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic list_result_t predict_list_op(op_t op, logic [INDEX_W-1:0] idx,
                                                     logic signed [DATA_W-1:0] val);
        list_result_t r;
        logic         in_range;
        r.rd     = '0;
        r.done   = 1'b0;
        in_range = int'(idx) < list_len;
        case (op)
            OP_APPEND:
            begin
                if (list_len < CAPACITY)
                begin
                    list_words[list_len] = val;
                    list_len++;
                    r.done = 1'b1;
                end
            end
            OP_SET:
            begin
                if (in_range)
                begin
                    list_words[idx] = val;
                    r.done = 1'b1;
                end
            end
            OP_GET:
            begin
                if (in_range)
                begin
                    r.rd   = list_words[idx];
                    r.done = 1'b1;
                end
            end
            default:
            begin
                if (in_range)
                begin
                    for (int i = int'(idx); i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    r.done = 1'b1;
                end
            end
        endcase
        r.len = LENGTH_W'(list_len);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(7, 0))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (list_len == 0 || $urandom_range(99, 0) < 15)
            return INDEX_W'($urandom_range(1023, 0));
        return INDEX_W'($urandom_range(list_len - 1, 0));
    endfunction

    task automatic send_request(input op_t op, input logic [INDEX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val,
                                input logic pinned, input list_result_t pinned_res);
        list_result_t want;
        int           gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        opcode   = op;
        index    = idx;
        value    = val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = predict_list_op(op, idx, val);
        if (pinned)
            want = pinned_res;
        pending_results.push_back(want);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input op_t op, input logic [INDEX_W-1:0] idx);
        list_result_t unused;
        unused = '0;
        send_request(op, idx, pick_word(), 1'b0, unused);
        if ($urandom_range(99, 0) == 0)
            wait_for_results();
    endtask

    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            case ($urandom_range(9, 0))
                0, 1, 2:
                begin
                    sink_mode = SINK_STEADY;
                    sink_left = $urandom_range(60, 20);
                end
                3, 4, 5:
                begin
                    sink_mode = SINK_HOLD;
                    sink_left = $urandom_range(12, 1);
                end
                default:
                begin
                    sink_mode = SINK_CHOPPY;
                    sink_left = $urandom_range(30, 5);
                end
            endcase
        end
        sink_left--;
        case (sink_mode)
            SINK_STEADY: out_ready = 1'b1;
            SINK_HOLD:   out_ready = 1'b0;
            default:     out_ready = 1'($urandom_range(1, 0));
        endcase
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with no request pending", $time);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.rd)
                begin
                    $display("%0t: read_value expected %0d, got %0d", $time, want.rd, read_value);
                    error_count++;
                end
                if (length !== want.len)
                begin
                    $display("%0t: length expected %0d, got %0d", $time, want.len, length);
                    error_count++;
                end
                if (done_res !== want.done)
                begin
                    $display("%0t: done_res expected %0b, got %0b", $time, want.done, done_res);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        list_result_t full_refusal;
        int           pick;
        op_t          op;

        directed_rows = '{
            '{OP_GET,    10'd0,    32'sd0,          1'b1, '{32'sd0,          11'd0, 1'b0}},
            '{OP_SET,    10'd0,    32'sd5,          1'b1, '{32'sd0,          11'd0, 1'b0}},
            '{OP_DELETE, 10'd0,    32'sd9,          1'b1, '{32'sd0,          11'd0, 1'b0}},
            '{OP_GET,    10'd1023, -32'sd1,         1'b1, '{32'sd0,          11'd0, 1'b0}},
            '{OP_APPEND, 10'd1023, 32'sh8000_0000,  1'b1, '{32'sd0,          11'd1, 1'b1}},
            '{OP_APPEND, 10'd0,    32'sh7FFF_FFFF,  1'b1, '{32'sd0,          11'd2, 1'b1}},
            '{OP_GET,    10'd0,    32'sd0,          1'b1, '{32'sh8000_0000,  11'd2, 1'b1}},
            '{OP_GET,    10'd1,    32'sd0,          1'b1, '{32'sh7FFF_FFFF,  11'd2, 1'b1}},
            '{OP_GET,    10'd2,    32'sd0,          1'b1, '{32'sd0,          11'd2, 1'b0}},
            '{OP_SET,    10'd1,    -32'sd1,         1'b1, '{32'sd0,          11'd2, 1'b1}},
            '{OP_GET,    10'd1,    32'sd0,          1'b1, '{-32'sd1,         11'd2, 1'b1}},
            '{OP_SET,    10'd2,    32'sd7,          1'b1, '{32'sd0,          11'd2, 1'b0}},
            '{OP_APPEND, 10'd512,  32'sd0,          1'b1, '{32'sd0,          11'd3, 1'b1}},
            '{OP_APPEND, 10'd0,    32'sh1234_5678,  1'b1, '{32'sd0,          11'd4, 1'b1}},
            '{OP_DELETE, 10'd4,    -32'sd1,         1'b1, '{32'sd0,          11'd4, 1'b0}},
            '{OP_DELETE, 10'd0,    32'sd0,          1'b1, '{32'sd0,          11'd3, 1'b1}},
            '{OP_GET,    10'd0,    32'sd0,          1'b0, '{32'sd0,          11'd0, 1'b0}},
            '{OP_DELETE, 10'd1,    32'sh5555_AAAA,  1'b0, '{32'sd0,          11'd0, 1'b0}},
            '{OP_GET,    10'd1,    32'sd0,          1'b0, '{32'sd0,          11'd0, 1'b0}},
            '{OP_DELETE, 10'd1,    32'sd0,          1'b0, '{32'sd0,          11'd0, 1'b0}},
            '{OP_DELETE, 10'd0,    32'sd0,          1'b1, '{32'sd0,          11'd0, 1'b1}},
            '{OP_GET,    10'd0,    32'sd0,          1'b1, '{32'sd0,          11'd0, 1'b0}},
            '{OP_APPEND, 10'd0,    -32'sd1,         1'b1, '{32'sd0,          11'd1, 1'b1}}
        };

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].pinned, directed_rows[i].res);
        wait_for_results();

        for (int n = 0; n < SHORT_LIST_OPS; n++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < ((list_len < 8) ? 60 : (list_len > 48 ? 15 : 30)))
                op = OP_APPEND;
            else if (pick < 65)
                op = OP_SET;
            else if (pick < 82)
                op = OP_GET;
            else
                op = OP_DELETE;
            send_random(op, (op == OP_APPEND) ? INDEX_W'($urandom_range(1023, 0)) : pick_index());
        end
        wait_for_results();

        while (list_len < CAPACITY)
            send_random(OP_APPEND, INDEX_W'($urandom_range(1023, 0)));
        full_refusal = '{32'sd0, LENGTH_W'(CAPACITY), 1'b0};
        send_request(OP_APPEND, 10'd0, 32'sh7FFF_FFFF, 1'b1, full_refusal);
        wait_for_results();

        for (int n = 0; n < FULL_LIST_OPS; n++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 20)
                op = OP_APPEND;
            else if (pick < 45)
                op = OP_SET;
            else if (pick < 82)
                op = OP_GET;
            else
                op = OP_DELETE;
            send_random(op, INDEX_W'($urandom_range(1023, 0)));
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("indexed_list_store_unit_test passed");
        else
            $display("indexed_list_store_unit_test failed");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("indexed_list_store_unit_test failed");
        $finish;
    end

endmodule
